### sv/dpa_pkg.sv
// ============================================================================
// dpa_pkg
// Shared types and codes for the double-ended pool allocator.
// ============================================================================
package dpa_pkg;

    // Byte offsets, tops and free count all fit in 17 bits
    localparam int ADDR_W   = 17;
    localparam int GRAN_W   = 13;   // granule number of a 17-bit offset
    localparam int HEADER_B = 16;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_PUSH   = 3'd2,
        OP_PULL   = 3'd3,
        OP_REINIT = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_BAD_ADDR = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // Register indexes on the config port
    localparam logic REG_POOL_START = 1'b0;
    localparam logic REG_POOL_END   = 1'b1;

    // Config register contents
    typedef struct packed {
        logic [15:0] pool_start;
        logic [16:0] pool_end;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch the input word
        logic calc;     // block size and target granule
        logic index;    // granule to link store index
        logic read;     // memory reads
        logic exec;     // apply the operation, load the result word
    } cmd_t;

endpackage

### sv/dpa_apb_regs.sv
// ============================================================================
// dpa_apb_regs
// APB-style config registers: pool_start and pool_end.
// ============================================================================
module dpa_apb_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output dpa_pkg::cfg_t cfg
);
    import dpa_pkg::*;

    logic [15:0] pool_start_reg;
    logic [16:0] pool_end_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg <= 16'd0;
            pool_end_reg   <= 17'h10000;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_POOL_START)
                pool_start_reg <= pwdata[15:0];
            else
                pool_end_reg <= pwdata[16:0];
        end
    end

    assign prdata = (paddr[2] == REG_POOL_END) ? {15'd0, pool_end_reg}
                                               : {16'd0, pool_start_reg};

    assign cfg.pool_start = pool_start_reg;
    assign cfg.pool_end   = pool_end_reg;

endmodule

### sv/dpa_ctrl.sv
// ============================================================================
// dpa_ctrl
// Sequencer: steps one word through calc, index, read and execute.
// ============================================================================
module dpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output dpa_pkg::cmd_t cmd
);
    import dpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_INDEX,
        S_READ,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load;

    // result slot is free when empty or being drained this cycle
    assign load = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CALC;
            end
            S_CALC:  state_next = S_INDEX;
            S_INDEX: state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;

    assign cmd.accept = (state_reg == S_IDLE) && in_valid;
    assign cmd.calc   = (state_reg == S_CALC);
    assign cmd.index  = (state_reg == S_INDEX);
    assign cmd.read   = (state_reg == S_READ);
    assign cmd.exec   = load;

endmodule

### sv/dpa_datapath.sv
// ============================================================================
// dpa_datapath
// Pool tops, free count, link store, frame stack and result word.
// ============================================================================
module dpa_datapath #(
    parameter int REGION_BYTES = 65536,
    parameter int FRAME_DEPTH  = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dpa_pkg::cmd_t cmd,
    input  dpa_pkg::cfg_t cfg,
    input  logic [2:0]    opcode,
    input  logic          from_high_end,
    input  logic [15:0]   request_bytes,
    input  logic [15:0]   user_address,
    output logic          granted,
    output logic [2:0]    status,
    output logic [15:0]   block_address,
    output logic [16:0]   pool_bytes,
    output logic [16:0]   available_bytes
);
    import dpa_pkg::*;

    // link store geometry; granule numbers never exceed 13 bits
    localparam int GRANULES   = REGION_BYTES / 16;
    localparam int LINK_DEPTH = (GRANULES < 8192) ? GRANULES : 8192;
    localparam int LIW        = $clog2(LINK_DEPTH);
    localparam logic [31:0] GRAN_MOD = 32'(GRANULES);

    // frame stack geometry
    localparam int DW  = $clog2(FRAME_DEPTH + 1);
    localparam int FIW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    // end clamp and reset values
    localparam int REGION_LIM = (REGION_BYTES > 131071) ? 131071 : REGION_BYTES;
    localparam logic [ADDR_W-1:0] REGION_CAP = ADDR_W'(REGION_LIM);
    localparam int RST_END = ((REGION_BYTES < 65536) ? REGION_BYTES : 65536) / 16 * 16;
    localparam logic [ADDR_W-1:0] RST_HBASE = ADDR_W'(RST_END - HEADER_B);
    localparam logic [ADDR_W-1:0] RST_FREE  = ADDR_W'(RST_END - 2 * HEADER_B);

    localparam logic [ADDR_W-1:0] HDR   = ADDR_W'(HEADER_B);
    localparam logic [ADDR_W-1:0] FRSZ  = ADDR_W'(2 * HEADER_B);
    localparam logic [ADDR_W-1:0] ALIGN = ~ADDR_W'(15);

    typedef struct packed {
        logic [ADDR_W-1:0] free_count;
        logic [ADDR_W-1:0] low_top;
        logic [ADDR_W-1:0] high_top;
    } frame_t;

    // architectural state
    logic [ADDR_W-1:0] low_base_reg, high_base_reg;
    logic [ADDR_W-1:0] low_top_reg, high_top_reg, free_reg;
    logic [DW-1:0]     depth_reg;

    // latched word and per-step registers
    opcode_t           op_reg;
    logic              high_reg;
    logic [15:0]       req_reg, user_reg;
    logic [ADDR_W-1:0] size_reg;
    logic [GRAN_W-1:0] gran_reg;
    logic [LIW-1:0]    idx_reg;
    logic [GRAN_W-1:0] link_q;
    frame_t            frame_q;

    // memories
    logic [GRAN_W-1:0] link_mem [LINK_DEPTH];
    frame_t            frame_mem [FRAME_DEPTH];

    // result word
    logic              granted_reg;
    status_t           status_reg;
    logic [15:0]       addr_reg;
    logic [ADDR_W-1:0] pool_reg, avail_reg;

    // ---------------------------------------------------------------- input
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode_t'(opcode);
            high_reg <= from_high_end;
            req_reg  <= request_bytes;
            user_reg <= user_address;
        end
    end

    // ---------------------------------------------------------------- calc
    logic [ADDR_W-1:0] size_c, new_top_c, hdr_c;

    assign size_c    = (op_reg == OP_PUSH) ? FRSZ
                     : ((({1'b0, req_reg} + ADDR_W'(15)) & ALIGN) + HDR);
    assign new_top_c = high_top_reg - size_c;
    assign hdr_c     = {1'b0, user_reg} - HDR;

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            size_reg <= size_c;
            gran_reg <= (op_reg == OP_FREE) ? hdr_c[ADDR_W-1:4] : new_top_c[ADDR_W-1:4];
        end
    end

    // ---------------------------------------------------------------- index
    // granule mod GRANULES by restoring subtraction; quotient < 128
    logic [31:0] mod_r;

    always_comb
    begin
        mod_r = {19'd0, gran_reg};
        for (int k = 6; k >= 0; k--)
        begin
            if (mod_r >= (GRAN_MOD << k))
                mod_r = mod_r - (GRAN_MOD << k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.index)
            idx_reg <= mod_r[LIW-1:0];
    end

    // ---------------------------------------------------------------- read
    logic [DW-1:0] depth_dec;
    assign depth_dec = depth_reg - DW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            link_q  <= link_mem[idx_reg];
            frame_q <= frame_mem[depth_dec[FIW-1:0]];
        end
    end

    // ---------------------------------------------------------------- exec
    logic [ADDR_W-1:0] lo_n, hi_n, free_n, lbase_n, hbase_n;
    logic [DW-1:0]     depth_n;
    logic              grant_n, link_we, frame_we;
    status_t           status_n;
    logic [ADDR_W-1:0] addr_n;

    logic              fits, bad_ptr;
    logic [ADDR_W-1:0] h_addr, next_hdr;
    logic [ADDR_W-1:0] ri_lo, ri_end, ri_hb;

    assign fits     = (size_reg <= free_reg);
    assign bad_ptr  = (user_reg < 16'(HEADER_B)) || (user_reg[3:0] != 4'd0);
    assign h_addr   = {1'b0, user_reg} - HDR;
    assign next_hdr = {link_q, 4'd0};

    assign ri_lo  = ({1'b0, cfg.pool_start} + ADDR_W'(15)) & ALIGN;
    assign ri_end = (cfg.pool_end > REGION_CAP) ? REGION_CAP : cfg.pool_end;
    assign ri_hb  = ri_end & ALIGN;

    always_comb
    begin
        lo_n     = low_top_reg;
        hi_n     = high_top_reg;
        free_n   = free_reg;
        lbase_n  = low_base_reg;
        hbase_n  = high_base_reg;
        depth_n  = depth_reg;
        grant_n  = 1'b0;
        status_n = ST_OK;
        addr_n   = '0;
        link_we  = 1'b0;
        frame_we = 1'b0;
        case (op_reg)
            OP_ALLOC:
            begin
                if (fits)
                begin
                    grant_n = 1'b1;
                    free_n  = free_reg - size_reg;
                    if (!high_reg)
                    begin
                        addr_n = low_top_reg + HDR;
                        lo_n   = low_top_reg + size_reg;
                    end
                    else
                    begin
                        hi_n    = high_top_reg - size_reg;
                        addr_n  = hi_n + HDR;
                        link_we = 1'b1;
                    end
                end
                else
                    status_n = ST_NO_SPACE;
            end
            OP_FREE:
            begin
                status_n = ST_BAD_ADDR;
                if (!bad_ptr)
                begin
                    if (h_addr < low_top_reg)
                    begin
                        if (h_addr >= low_base_reg)
                        begin
                            grant_n  = 1'b1;
                            status_n = ST_OK;
                            free_n   = free_reg + (low_top_reg - h_addr);
                            lo_n     = h_addr;
                        end
                    end
                    else if (h_addr >= high_top_reg && h_addr < high_base_reg)
                    begin
                        // link must point above this header and inside the pool
                        if (next_hdr > h_addr && next_hdr <= high_base_reg)
                        begin
                            grant_n  = 1'b1;
                            status_n = ST_OK;
                            free_n   = free_reg + (next_hdr - high_top_reg);
                            hi_n     = next_hdr;
                        end
                    end
                end
            end
            OP_PUSH:
            begin
                if (depth_reg >= DW'(FRAME_DEPTH))
                    status_n = ST_FULL;
                else if (fits)
                begin
                    grant_n  = 1'b1;
                    frame_we = 1'b1;
                    depth_n  = depth_reg + DW'(1);
                    free_n   = free_reg - size_reg;
                    addr_n   = low_top_reg + HDR;
                    lo_n     = low_top_reg + size_reg;
                end
                else
                    status_n = ST_NO_SPACE;
            end
            OP_PULL:
            begin
                if (depth_reg == '0)
                    status_n = ST_EMPTY;
                else
                begin
                    grant_n = 1'b1;
                    depth_n = depth_dec;
                    free_n  = frame_q.free_count;
                    lo_n    = frame_q.low_top;
                    hi_n    = frame_q.high_top;
                end
            end
            OP_REINIT:
            begin
                grant_n = 1'b1;
                depth_n = '0;
                lbase_n = ri_lo;
                lo_n    = ri_lo;
                if (ri_hb >= ri_lo + FRSZ)
                begin
                    hbase_n = ri_hb - HDR;
                    hi_n    = ri_hb - HDR;
                    free_n  = ri_hb - HDR - ri_lo - HDR;
                end
                else
                begin
                    // region too small for two headers
                    hbase_n = ri_lo + HDR;
                    hi_n    = ri_lo + HDR;
                    free_n  = '0;
                end
            end
            default: status_n = ST_BAD_ADDR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_base_reg  <= '0;
            low_top_reg   <= '0;
            high_base_reg <= RST_HBASE;
            high_top_reg  <= RST_HBASE;
            free_reg      <= RST_FREE;
            depth_reg     <= '0;
        end
        else if (cmd.exec)
        begin
            low_base_reg  <= lbase_n;
            low_top_reg   <= lo_n;
            high_base_reg <= hbase_n;
            high_top_reg  <= hi_n;
            free_reg      <= free_n;
            depth_reg     <= depth_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && link_we)
            link_mem[idx_reg] <= high_top_reg[ADDR_W-1:4];
        if (cmd.exec && frame_we)
            frame_mem[depth_reg[FIW-1:0]] <= '{free_count: free_reg,
                                               low_top:    low_top_reg,
                                               high_top:   high_top_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            granted_reg <= grant_n;
            status_reg  <= status_n;
            addr_reg    <= addr_n[15:0];
            pool_reg    <= free_n;
            avail_reg   <= (free_n > HDR) ? (free_n - HDR) : '0;
        end
    end

    assign granted         = granted_reg;
    assign status          = status_reg;
    assign block_address   = addr_reg;
    assign pool_bytes      = pool_reg;
    assign available_bytes = avail_reg;

endmodule

### sv/double_ended_pool_allocator.sv
// ============================================================================
// double_ended_pool_allocator
// One word at a time: the input stalls until the result word of the last one is loaded.
// The sequencer steps calc, index (granule mod), memory read, execute per word;
// the link store and frame stack are read through a register in the read step.
// Reset clears tops, free count and frame depth to the default region at once;
// link store and frame stack hold no reset; a free may read a link never written.
// ============================================================================
module double_ended_pool_allocator #(
    parameter int REGION_BYTES = 65536,
    parameter int FRAME_DEPTH  = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // operation word in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic        from_high_end,
    input  logic [15:0] request_bytes,
    input  logic [15:0] user_address,

    // result word out
    output logic        out_valid,
    input  logic        out_stall,
    output logic        granted,
    output logic [2:0]  status,
    output logic [15:0] block_address,
    output logic [16:0] pool_bytes,
    output logic [16:0] available_bytes
);
    import dpa_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    // pool_start at 0, pool_end at 4; writes take effect at the next reinit
    dpa_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: holds the input off while a word is in flight,
    // owns the result valid so a new word can enter while one waits
    dpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // tops, free count, high-side links, frame stack, result registers
    dpa_datapath #(
        .REGION_BYTES (REGION_BYTES),
        .FRAME_DEPTH  (FRAME_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg),
        .opcode          (opcode),
        .from_high_end   (from_high_end),
        .request_bytes   (request_bytes),
        .user_address    (user_address),
        .granted         (granted),
        .status          (status),
        .block_address   (block_address),
        .pool_bytes      (pool_bytes),
        .available_bytes (available_bytes)
    );

endmodule

### tb/pool_tb_pkg.sv
// ============================================================================
// pool_tb_pkg
// Scoreboard for the double-ended pool allocator: a cycle-free mirror of the
// two stacks, the link store and the frame stack that predicts every result
// word, plus an in-order check of the words that come out of the block.
// ============================================================================
`timescale 1ns / 1ps

package pool_tb_pkg;
    import dpa_pkg::*;

    localparam int unsigned REGION   = 65536;
    localparam int unsigned GRANULES = REGION / 16;
    localparam int unsigned FRAMES   = 8;
    localparam int unsigned FRAME_B  = 16;

    // opcodes the block does not define
    localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        from_high_end;
        logic [15:0] request_bytes;
        logic [15:0] user_address;
    } op_word_t;

    typedef struct packed {
        logic        granted;
        logic [2:0]  status;
        logic [15:0] block_address;
        logic [16:0] pool_bytes;
        logic [16:0] available_bytes;
    } result_word_t;

    typedef struct {
        int unsigned free_count;
        int unsigned low_top;
        int unsigned high_top;
    } saved_tops_t;

    class pool_scoreboard;
        // register shadows; they only take hold at reinit
        int unsigned cfg_start = 0;
        int unsigned cfg_end   = REGION;

        int unsigned low_base, high_base, low_top, high_top, free_count;
        logic [12:0] link_store [GRANULES];
        bit          link_written [GRANULES];
        saved_tops_t frames [FRAMES];
        int unsigned frame_depth;

        result_word_t results_owed [$];
        int unsigned  mismatches;
        int unsigned  words_seen;
        int unsigned  status_seen [8];

        function new();
            frame_depth = 0;
            mismatches  = 0;
            words_seen  = 0;
            reinit_tops();
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_POOL_START)
                cfg_start = 32'(value[15:0]);
            else
                cfg_end = 32'(value[16:0]);
        endfunction

        function void reinit_tops();
            int unsigned lo, top_end, hb;
            lo      = (cfg_start + 15) & ~32'd15;
            top_end = (cfg_end > REGION) ? REGION : cfg_end;
            hb      = top_end & ~32'd15;
            low_base = lo;
            low_top  = lo;
            if (hb >= lo + 2 * HEADER_B)
            begin
                high_base  = hb - HEADER_B;
                free_count = high_base - lo - HEADER_B;
            end
            else
            begin
                // too small for two headers: no block can ever be granted
                high_base  = lo + HEADER_B;
                free_count = 0;
            end
            high_top = high_base;
        endfunction

        // returns the user pointer, 0 when the block does not fit
        function int unsigned carve(int unsigned bytes, bit from_high);
            int unsigned size, old_top, g;
            size = ((bytes + 15) & ~32'd15) + HEADER_B;
            if (size > free_count)
                return 0;
            free_count -= size;
            if (!from_high)
            begin
                low_top += size;
                return low_top - size + HEADER_B;
            end
            old_top  = high_top;
            high_top -= size;
            g = (high_top >> 4) % GRANULES;
            link_store[g]   = 13'(old_top >> 4);
            link_written[g] = 1'b1;
            return high_top + HEADER_B;
        endfunction

        function bit give_back(int unsigned user);
            int unsigned h, nxt;
            if (user < HEADER_B || (user & 15) != 0)
                return 0;
            h = user - HEADER_B;
            if (h < low_top)
            begin
                if (h < low_base)
                    return 0;
                free_count += low_top - h;
                low_top = h;
                return 1;
            end
            if (h >= high_top && h < high_base)
            begin
                nxt = 32'(link_store[(h >> 4) % GRANULES]) << 4;
                if (nxt <= h || nxt > high_base)
                    return 0;
                free_count += nxt - high_top;
                high_top = nxt;
                return 1;
            end
            return 0;
        endfunction

        // 0 when a free of this pointer would read a link never written
        function bit link_read_safe(int unsigned user);
            int unsigned h;
            if (user < HEADER_B || (user & 15) != 0)
                return 1;
            h = user - HEADER_B;
            if (h < low_top)
                return 1;
            if (h >= high_top && h < high_base)
                return link_written[(h >> 4) % GRANULES];
            return 1;
        endfunction

        function result_word_t apply_op(op_word_t w);
            result_word_t r;
            int unsigned  addr;
            saved_tops_t  snap;
            status_t      st;
            addr      = 0;
            st        = ST_OK;
            r.granted = 1'b0;
            case (w.opcode)
                OP_ALLOC:
                begin
                    addr = carve(32'(w.request_bytes), w.from_high_end);
                    if (addr != 0)
                        r.granted = 1'b1;
                    else
                        st = ST_NO_SPACE;
                end
                OP_FREE:
                begin
                    if (give_back(32'(w.user_address)))
                        r.granted = 1'b1;
                    else
                        st = ST_BAD_ADDR;
                end
                OP_PUSH:
                begin
                    if (frame_depth >= FRAMES)
                        st = ST_FULL;
                    else
                    begin
                        snap.free_count = free_count;
                        snap.low_top    = low_top;
                        snap.high_top   = high_top;
                        addr = carve(FRAME_B, 1'b0);
                        if (addr != 0)
                        begin
                            frames[frame_depth] = snap;
                            frame_depth++;
                            r.granted = 1'b1;
                        end
                        else
                            st = ST_NO_SPACE;
                    end
                end
                OP_PULL:
                begin
                    if (frame_depth == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        frame_depth--;
                        free_count = frames[frame_depth].free_count;
                        low_top    = frames[frame_depth].low_top;
                        high_top   = frames[frame_depth].high_top;
                        r.granted  = 1'b1;
                    end
                end
                OP_REINIT:
                begin
                    reinit_tops();
                    frame_depth = 0;
                    r.granted   = 1'b1;
                end
                default:
                    st = ST_BAD_ADDR;
            endcase
            r.status          = st;
            r.block_address   = 16'(addr);
            r.pool_bytes      = 17'(free_count);
            r.available_bytes = (free_count > HEADER_B) ? 17'(free_count - HEADER_B) : 17'd0;
            return r;
        endfunction

        function result_word_t note_op(op_word_t w);
            result_word_t r;
            r = apply_op(w);
            results_owed.push_back(r);
            return r;
        endfunction

        function int pending();
            return results_owed.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(result_word_t got);
            result_word_t want;
            if (results_owed.size() == 0)
            begin
                report_mismatch("result word with no operation outstanding");
                return;
            end
            want = results_owed.pop_front();
            words_seen++;
            status_seen[want.status]++;
            if (got.granted !== want.granted)
                report_mismatch($sformatf("word %0d granted %0b, want %0b",
                                          words_seen, got.granted, want.granted));
            if (got.status !== want.status)
                report_mismatch($sformatf("word %0d status %0d, want %0d",
                                          words_seen, got.status, want.status));
            if (got.block_address !== want.block_address)
                report_mismatch($sformatf("word %0d block_address %h, want %h",
                                          words_seen, got.block_address, want.block_address));
            if (got.pool_bytes !== want.pool_bytes)
                report_mismatch($sformatf("word %0d pool_bytes %0d, want %0d",
                                          words_seen, got.pool_bytes, want.pool_bytes));
            if (got.available_bytes !== want.available_bytes)
                report_mismatch($sformatf("word %0d available_bytes %0d, want %0d",
                                          words_seen, got.available_bytes,
                                          want.available_bytes));
        endtask
    endclass

endpackage

### tb/tb.sv
// ============================================================================
// tb
// Top-level bench for double_ended_pool_allocator. A directed opening walks
// the corner cases (empty and full frame stack, no space, bad pointers, a
// stale high-side link); random traffic then runs over several region
// settings with random idling on both sides and one long output hold-off.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import dpa_pkg::*;
    import pool_tb_pkg::*;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode        = OP_ALLOC;
    logic        from_high_end = 1'b0;
    logic [15:0] request_bytes = '0;
    logic [15:0] user_address  = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        granted;
    logic [2:0]  status;
    logic [15:0] block_address;
    logic [16:0] pool_bytes;
    logic [16:0] available_bytes;

    pool_scoreboard sb;
    result_word_t   last_result;     // prediction for the word just accepted
    logic [15:0]    handed_out [$];  // pointers returned lately, for frees
    int unsigned    ops_sent      = 0;
    int unsigned    results_taken = 0;
    int unsigned    regions_used  = 1;
    int unsigned    send_calm     = 0;
    int unsigned    recv_calm     = 0;

    double_ended_pool_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .from_high_end   (from_high_end),
        .request_bytes   (request_bytes),
        .user_address    (user_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted         (granted),
        .status          (status),
        .block_address   (block_address),
        .pool_bytes      (pool_bytes),
        .available_bytes (available_bytes)
    );

    always #2 clk = ~clk;

    // Idle lengths: mostly none or short, a few long, and now and then a
    // calm stretch with no idling at all.
    function automatic int unsigned pick_gap(inout int unsigned calm_left);
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(13, 60);
    endfunction

    // Fields an operation ignores still carry random bits.
    function automatic op_word_t blank_op(input logic [2:0] code);
        op_word_t w;
        w.opcode        = code;
        w.from_high_end = 1'($urandom);
        w.request_bytes = 16'($urandom);
        w.user_address  = 16'($urandom);
        return w;
    endfunction

    function automatic op_word_t alloc_op(input logic high, input logic [15:0] bytes);
        op_word_t w;
        w = blank_op(OP_ALLOC);
        w.from_high_end = high;
        w.request_bytes = bytes;
        return w;
    endfunction

    // A free that would read a high-side link never written is turned into a
    // misaligned pointer, which the block rejects without touching the store.
    function automatic op_word_t free_op(input logic [15:0] addr);
        op_word_t w;
        w = blank_op(OP_FREE);
        w.user_address = sb.link_read_safe(32'(addr)) ? addr : (addr | 16'd1);
        return w;
    endfunction

    // Mostly well-formed traffic: allocations, frees of pointers handed out,
    // frame push/pull. The rest is noise: wild pointers, near misses,
    // undefined opcodes and huge requests.
    function automatic op_word_t random_op();
        op_word_t    w;
        int unsigned r, s;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        w = blank_op(OP_ALLOC);
        if (r < 40)
        begin
            s = $urandom_range(0, 99);
            if (s < 85)
                w.request_bytes = 16'($urandom_range(0, 600));
            else if (s < 97)
                w.request_bytes = 16'($urandom_range(601, 8000));
        end
        else if (r < 62 && handed_out.size() != 0)
            w = free_op(handed_out[$urandom_range(0, handed_out.size() - 1)]);
        else if (r < 70)
            w.opcode = OP_PUSH;
        else if (r < 78)
            w.opcode = OP_PULL;
        else if (r < 80)
            w.opcode = OP_REINIT;
        else if (r < 88)
            w = free_op(16'($urandom));
        else if (r < 93 && handed_out.size() != 0)
        begin
            a = handed_out[$urandom_range(0, handed_out.size() - 1)];
            w = free_op(a + 16'($urandom_range(0, 47)) - 16'd24);
        end
        else if (r < 97)
            w.opcode = 3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
        // else: allocate with fully random size and side
        return w;
    endfunction

    // Offer one word and hold it until taken. Starts and ends at a falling edge.
    task automatic send_op(input op_word_t w);
        int unsigned idle_cycles;
        idle_cycles = pick_gap(send_calm);
        if (idle_cycles != 0)
        begin
            in_valid = 1'b0;
            repeat (idle_cycles) @(negedge clk);
        end
        opcode        = w.opcode;
        from_high_end = w.from_high_end;
        request_bytes = w.request_bytes;
        user_address  = w.user_address;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        last_result = sb.note_op(w);
        ops_sent++;
        if (last_result.granted && last_result.block_address != 16'd0)
        begin
            handed_out.push_back(last_result.block_address);
            if (handed_out.size() > 48)
                void'(handed_out.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count)
            send_op(random_op());
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain, rewrite both registers, show that the old region still holds
    // until reinit, then reinit onto the new one.
    task automatic start_region(input int unsigned start_b, input int unsigned end_b);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        write_reg(REG_POOL_START, 32'(start_b));
        write_reg(REG_POOL_END, 32'(end_b));
        send_op(alloc_op(1'b0, 16'd0));
        send_op(blank_op(OP_REINIT));
        regions_used++;
    endtask

    // Result monitor: every word taken is checked against the oldest prediction.
    always @(posedge clk)
    begin : watch_results
        result_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.granted         = granted;
            got.status          = status;
            got.block_address   = block_address;
            got.pool_bytes      = pool_bytes;
            got.available_bytes = available_bytes;
            sb.check_result(got);
            results_taken++;
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps
    // offering, so the block backs up and stalls its input.
    initial
    begin : receiver_side
        int unsigned stall_cycles;
        bit          held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_taken >= 200)
            begin
                held_off  = 1'b1;
                out_stall = 1'b1;
                repeat (400) @(negedge clk);
                out_stall = 1'b0;
            end
            else
            begin
                stall_cycles = pick_gap(recv_calm);
                if (stall_cycles != 0)
                begin
                    out_stall = 1'b1;
                    repeat (stall_cycles) @(negedge clk);
                    out_stall = 1'b0;
                end
            end
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        op_word_t    w;
        logic [15:0] low_a, low_b, high_a, stale_high;
        sb = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed opening, default region from reset ----
        send_op(blank_op(OP_PULL));                 // empty frame stack
        send_op(alloc_op(1'b0, 16'd0));             // zero-byte request
        low_a = last_result.block_address;
        send_op(alloc_op(1'b0, 16'd1));
        low_b = last_result.block_address;
        send_op(alloc_op(1'b1, 16'hFFFF));          // can never fit
        send_op(alloc_op(1'b1, 16'd17));
        high_a = last_result.block_address;
        send_op(alloc_op(1'b1, 16'd0));
        send_op(free_op(low_a + 16'd8));            // misaligned pointer
        send_op(free_op(16'd0));                    // below one header
        send_op(free_op(16'h8000));                 // in the gap between the tops
        send_op(free_op(high_a));                   // frees the high block below too
        send_op(free_op(low_b));
        repeat (FRAMES + 1)
            send_op(blank_op(OP_PUSH));             // the last one finds the stack full
        send_op(blank_op(OP_PULL));
        w = blank_op(OP_UNKNOWN_LAST);
        w.from_high_end = 1'b1;
        w.request_bytes = '1;
        w.user_address  = '1;
        send_op(w);
        // Stale link: a high block from a larger region, then a smaller region
        // whose new block covers that header. Its link points past the new end.
        send_op(alloc_op(1'b1, 16'd1024));
        stale_high = last_result.block_address;
        start_region(0, 65000);
        send_op(alloc_op(1'b1, 16'd1024));
        send_op(free_op(stale_high));

        // ---- random traffic over several regions ----
        run_random(380);
        start_region(16'h1234, 17'h05005);          // misaligned start and end
        run_random(200);
        start_region(65535, 0);                     // end below start: tiny region
        run_random(20);
        start_region(65500, 131071);                // end clamped, exactly two headers
        run_random(20);
        start_region(16, 600);                      // small pool: no space, frames run out
        run_random(150);
        start_region(0, 131071);                    // whole region, end clamped
        run_random(130);

        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d operations over %0d region settings; %0d result words checked.",
                 ops_sent, regions_used, sb.words_seen);
        $display("Outcomes: %0d ok, %0d no space, %0d bad address, %0d frames full, %0d empty.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NO_SPACE],
                 sb.status_seen[ST_BAD_ADDR], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY]);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin : watchdog
        #3_000_000;
        $display("Timed out with %0d result words still outstanding", sb.pending());
        $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/dpa_pkg.sv
sv/dpa_apb_regs.sv
sv/dpa_ctrl.sv
sv/dpa_datapath.sv
sv/double_ended_pool_allocator.sv
tb/pool_tb_pkg.sv
tb/tb.sv
